@@ rtl/box_blur_3x3_edge_aware_assert.svh @@
// Assertion macros for the box blur block.
// No dependencies; included by the top level.
`ifndef BOX_BLUR_3X3_EDGE_AWARE_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_ASSERT_SVH

// checked outside reset
`define BB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked always, reset included
`define BB_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/bblur_pkg.sv @@
// Package for the box blur block: payload structs, sizes, reciprocal table.
// No dependencies.
package bblur_pkg;

   localparam int MaxWidth = 1024;
   localparam int ColBits  = $clog2(MaxWidth);

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       frame_end;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_SUM  = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_CORR = 5'b10000
   } state_type;

   // floor(65536 / (2n)) for the neighbour counts that occur
   function automatic logic [15:0] recip(input logic [3:0] n);
      logic [15:0] r;
      case (n)
         4'd1:    r = 16'd32768;
         4'd2:    r = 16'd16384;
         4'd3:    r = 16'd10922;
         4'd4:    r = 16'd8192;
         4'd6:    r = 16'd5461;
         4'd9:    r = 16'd3640;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/box_blur_3x3_edge_aware.sv @@
// A pixel transaction that yields a result passes ST_READ, ST_SUM, ST_MUL and ST_CORR
// before rsp_valid; ST_CORR holds while rsp stalls. One without a result goes from ST_READ
// back to ST_IDLE; a dropped one stays in ST_IDLE. req_ready is high only in ST_IDLE.
// Reset clears control, positions, window and registers (640 x 480); the line stores
// are not cleared.
// Depends on bblur_pkg and box_blur_3x3_edge_aware_assert.svh.
module box_blur_3x3_edge_aware
   import bblur_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

`include "box_blur_3x3_edge_aware_assert.svh"

   state_type state_ff, state_in;

   logic [10:0] width_ff;
   logic [11:0] height_ff;
   logic [10:0] w_eff;
   logic [11:0] h_eff;

   logic [ColBits-1:0] in_col_ff;
   logic [12:0]        in_row_ff;
   logic [ColBits-1:0] out_col_ff;
   logic [11:0]        out_row_ff;

   logic [ColBits-1:0] col_ff;
   logic [23:0]        pix_ff;
   logic               emit_ff;

   logic [23:0] mem_top [MaxWidth];
   logic [23:0] mem_mid [MaxWidth];
   logic [23:0] rd_top_ff, rd_mid_ff;

   logic [23:0] win_ff [3][3];
   logic        fl_ff, fr_ff, ft_ff, fb_ff, last_ff;

   logic [12:0] x_ff [3];
   logic [3:0]  n_ff;
   logic [8:0]  q_ff [3];

   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   logic req_acc, item_ok, cfg_wr, rsp_free;
   logic [10:0] col_inc;
   logic [11:0] sum_ch [3];
   logic [3:0]  ncols, nrows;
   logic [28:0] prod [3];
   logic [13:0] back [3];
   logic [12:0] rem_ch [3];
   logic [7:0]  qout [3];

   function automatic logic last_ff_next();
      return (({1'b0, out_row_ff} + 13'd1) >= {1'b0, h_eff}) &&
             (({1'b0, out_col_ff} + 11'd1) >= w_eff);
   endfunction

   assign pready    = 1'b1;
   assign cfg_wr    = psel && penable && pwrite;
   assign prdata    = (paddr[2] == REG_HEIGHT) ? {20'd0, height_ff} : {21'd0, width_ff};
   assign w_eff     = (width_ff == 11'd0) ? 11'd1 :
                      (width_ff > 11'(MaxWidth)) ? 11'(MaxWidth) : width_ff;
   assign h_eff     = (height_ff == 12'd0) ? 12'd1 : height_ff;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign item_ok   = (req_data.op == OP_DRAIN) == (in_row_ff >= {1'b0, h_eff});
   assign col_inc   = {1'b0, in_col_ff} + 11'd1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_acc && item_ok) state_in = ST_READ;
         ST_READ: state_in = emit_ff ? ST_SUM : ST_IDLE;
         ST_SUM:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_CORR;
         ST_CORR: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // neighbour sums
   always_comb begin
      ncols = 4'd1 + {3'b0, fl_ff} + {3'b0, fr_ff};
      nrows = 4'd1 + {3'b0, ft_ff} + {3'b0, fb_ff};
      for (int ch = 0; ch < 3; ch++) begin
         sum_ch[ch] = '0;
         for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) begin
               if ((c != 0 || fl_ff) && (c != 2 || fr_ff) &&
                   (k != 0 || ft_ff) && (k != 2 || fb_ff)) begin
                  sum_ch[ch] = sum_ch[ch] + 12'(win_ff[c][k][8*(2-ch) +: 8]);
               end
            end
         end
      end
   end

   // reciprocal estimate and one-step correction
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch]   = 29'(x_ff[ch]) * 29'(recip(n_ff));
         back[ch]   = 14'(q_ff[ch]) * 14'({n_ff, 1'b0});
         rem_ch[ch] = x_ff[ch] - back[ch][12:0];
         qout[ch]   = (rem_ch[ch] >= 13'({n_ff, 1'b0})) ? q_ff[ch][7:0] + 8'd1
                                                          : q_ff[ch][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         rd_top_ff <= mem_top[in_col_ff];
         rd_mid_ff <= mem_mid[in_col_ff];
      end
      if (state_ff == ST_READ) begin
         mem_top[col_ff] <= rd_mid_ff;
         mem_mid[col_ff] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         col_ff  <= in_col_ff;
         pix_ff  <= (req_data.op == OP_DRAIN) ? 24'd0 :
                    {req_data.red_in, req_data.green_in, req_data.blue_in};
         emit_ff <= (in_row_ff >= 13'd2) || (in_row_ff == 13'd1 && in_col_ff != '0);
      end
      if (state_ff == ST_READ) begin
         fl_ff   <= out_col_ff != '0;
         fr_ff   <= ({1'b0, out_col_ff} + 11'd1) < w_eff;
         ft_ff   <= out_row_ff != '0;
         fb_ff   <= ({1'b0, out_row_ff} + 13'd1) < {1'b0, h_eff};
         last_ff <= (({1'b0, out_row_ff} + 13'd1) >= {1'b0, h_eff}) &&
                    (({1'b0, out_col_ff} + 11'd1) >= w_eff);
      end
      if (state_ff == ST_SUM) begin
         n_ff <= ncols * nrows;
         for (int ch = 0; ch < 3; ch++) begin
            x_ff[ch] <= {sum_ch[ch], 1'b0} + {9'd0, ncols * nrows};
         end
      end
      if (state_ff == ST_MUL) begin
         for (int ch = 0; ch < 3; ch++) q_ff[ch] <= prod[ch][24:16];
      end
      if (state_ff == ST_CORR && rsp_free) begin
         rsp_ff <= '{red_out: qout[0], green_out: qout[1], blue_out: qout[2],
                     frame_end: last_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= 11'd640;
         height_ff    <= 12'd480;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) win_ff[c][k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_CORR && rsp_free) rsp_valid_ff <= 1'b1;
         if (cfg_wr) begin
            if (paddr[2] == REG_WIDTH) width_ff <= pwdata[10:0];
            else                        height_ff <= pwdata[11:0];
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end
         if (req_acc && item_ok) begin
            if (col_inc >= w_eff) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + 13'd1;
            end else begin
               in_col_ff <= col_inc[ColBits-1:0];
            end
         end
         if (state_ff == ST_READ) begin
            win_ff[0] <= win_ff[1];
            win_ff[1] <= win_ff[2];
            win_ff[2] <= '{rd_top_ff, rd_mid_ff, pix_ff};
            if (emit_ff) begin
               if (last_ff_next()) begin
                  out_col_ff <= '0;
                  out_row_ff <= '0;
                  in_col_ff  <= '0;
                  in_row_ff  <= '0;
               end else if (({1'b0, out_col_ff} + 11'd1) >= w_eff) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + 12'd1;
               end else begin
                  out_col_ff <= out_col_ff + ColBits'(1);
               end
            end
         end
      end
   end

   `BB_ASSERT(a_state_onehot, $onehot(state_ff), "state not one-hot")
   `BB_ASSERT(a_div_nonzero, (state_ff == ST_MUL) |-> (n_ff != 4'd0), "zero neighbour count")
   `BB_ASSERT(a_last_restart,
      (state_ff == ST_READ && emit_ff && last_ff_next()) |=>
      (out_col_ff == '0 && out_row_ff == '0 && in_row_ff == '0), "frame not restarted")
   `BB_ASSERT(a_ready_idle_rsp,
      (state_ff == ST_CORR && !rsp_free) |=> (state_ff == ST_CORR), "result dropped")

endmodule

@@ sim/box_blur_3x3_edge_aware_tb.sv @@
// Testbench for box_blur_3x3_edge_aware: raster frames of RGB pixels and drain ticks
// go in, each blurred pixel is checked against a behavioral predictor or a tabled value.
// Depends on bblur_pkg and the box_blur_3x3_edge_aware RTL.
module box_blur_3x3_edge_aware_tb;
   import bblur_pkg::*;

   typedef struct {
      int         cw;      // < 0: keep configuration
      int         ch;
      logic       op;
      logic [7:0] rr;
      logic [7:0] gg;
      logic [7:0] bb;
      bit         typed;
      rsp_type    want;
   } stim_row;

   localparam logic [2:0] AddrWidth  = 3'd0;
   localparam logic [2:0] AddrHeight = 3'd4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   box_blur_3x3_edge_aware uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [23:0] line_mem [2][MaxWidth];
   logic [23:0] win [3][3];
   int          cfg_w, cfg_h, col_in, row_in, col_out, row_out;
   rsp_type     blur_due [$];
   int          mismatches = 0;
   int          items_sent = 0;
   bit          quiet = 1'b0;

   function automatic int used_width();
      if (cfg_w == 0) return 1;
      if (cfg_w > MaxWidth) return MaxWidth;
      return cfg_w;
   endfunction

   function automatic int used_height();
      return (cfg_h == 0) ? 1 : cfg_h;
   endfunction

   function automatic logic [7:0] chan_mean(int sh, bit l, bit r, bit t, bit b);
      int sum, n;
      sum = 0;
      n = 0;
      for (int c = 0; c < 3; c++) begin
         if ((c == 0 && !l) || (c == 2 && !r)) continue;
         for (int k = 0; k < 3; k++) begin
            if ((k == 0 && !t) || (k == 2 && !b)) continue;
            sum += (win[c][k] >> sh) & 8'hFF;
            n++;
         end
      end
      return (2 * sum + n) / (2 * n);
   endfunction

   function automatic void blur_step(input req_type t, output bit took, output bit got,
                                     output rsp_type r);
      int w, h;
      bit drain, emit, last;
      logic [23:0] pix, top, mid;
      w = used_width();
      h = used_height();
      drain = (t.op == OP_DRAIN);
      took = 1'b0;
      got = 1'b0;
      r = '0;
      if (drain != (row_in >= h)) return;
      took = 1'b1;
      pix = drain ? 24'd0 : {t.red_in, t.green_in, t.blue_in};
      if (col_in >= MaxWidth) col_in = 0;
      top = line_mem[0][col_in];
      mid = line_mem[1][col_in];
      line_mem[0][col_in] = mid;
      line_mem[1][col_in] = pix;
      for (int c = 0; c < 2; c++)
         for (int k = 0; k < 3; k++)
            win[c][k] = win[c + 1][k];
      win[2][0] = top;
      win[2][1] = mid;
      win[2][2] = pix;
      emit = row_in >= 2 || (row_in == 1 && col_in >= 1);
      col_in++;
      if (col_in >= w) begin
         col_in = 0;
         row_in++;
      end
      if (!emit) return;
      got = 1'b1;
      last = (row_out + 1 >= h) && (col_out + 1 >= w);
      r.red_out   = chan_mean(16, col_out > 0, col_out + 1 < w, row_out > 0, row_out + 1 < h);
      r.green_out = chan_mean(8, col_out > 0, col_out + 1 < w, row_out > 0, row_out + 1 < h);
      r.blue_out  = chan_mean(0, col_out > 0, col_out + 1 < w, row_out > 0, row_out + 1 < h);
      r.frame_end = last;
      if (last) begin
         col_in = 0;
         row_in = 0;
         col_out = 0;
         row_out = 0;
      end else begin
         col_out++;
         if (col_out >= w) begin
            col_out = 0;
            row_out++;
         end
      end
   endfunction

   function automatic int draw_gap();
      if (quiet) return 0;
      return $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : $urandom_range(0, 2);
   endfunction

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      paddr = addr;
      pwdata = value;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      if (addr == AddrWidth) cfg_w = value & 32'h7FF;
      else cfg_h = value & 32'hFFF;
      col_in = 0;
      row_in = 0;
      col_out = 0;
      row_out = 0;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic configure(input int w, input int h);
      @(negedge clock);
      req_valid = 1'b0;
      wait (blur_due.size() == 0);
      repeat (12) @(posedge clock);
      csr_write(AddrWidth, w);
      csr_write(AddrHeight, h);
   endtask

   // valid stays high between back-to-back transactions
   task automatic send(input req_type t, input bit typed, input rsp_type want);
      int gap;
      bit took, got;
      rsp_type r;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = t;
      do @(posedge clock); while (!req_ready);
      blur_step(t, took, got, r);
      items_sent++;
      if (typed) blur_due.push_back(want);
      else if (got) blur_due.push_back(r);
   endtask

   function automatic req_type rand_pixel(input logic op);
      req_type t;
      t.op = op;
      t.red_in = 8'($urandom);
      t.green_in = 8'($urandom);
      t.blue_in = 8'($urandom);
      return t;
   endfunction

   // one frame with noise; abort_at >= 0 stops it after that many pixels
   task automatic run_frame(input int abort_at);
      int n;
      n = used_width() * used_height();
      for (int i = 0; i < n; i++) begin
         if (i == abort_at) return;
         if ($urandom_range(0, 19) == 0) send(rand_pixel(OP_DRAIN), 1'b0, '0);
         send(rand_pixel(OP_PIXEL), 1'b0, '0);
      end
      for (int i = 0; i <= used_width(); i++) begin
         if ($urandom_range(0, 19) == 0) send(rand_pixel(OP_PIXEL), 1'b0, '0);
         send(rand_pixel(OP_DRAIN), 1'b0, '0);
      end
   endtask

   stim_row dir_rows [18] = '{
      '{1, 1, OP_DRAIN, 8'd9, 8'd9, 8'd9, 1'b0, '0},
      '{-1, -1, OP_PIXEL, 8'd255, 8'd0, 8'd128, 1'b0, '0},
      '{-1, -1, OP_PIXEL, 8'd1, 8'd2, 8'd3, 1'b0, '0},
      '{-1, -1, OP_DRAIN, 8'd0, 8'd0, 8'd0, 1'b0, '0},
      '{-1, -1, OP_DRAIN, 8'd0, 8'd0, 8'd0, 1'b1, '{8'd255, 8'd0, 8'd128, 1'b1}},
      '{3, 3, OP_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0},
      '{-1, -1, OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, '0},
      '{-1, -1, OP_PIXEL, 8'd0, 8'd255, 8'd0, 1'b0, '0},
      '{-1, -1, OP_PIXEL, 8'd255, 8'd0, 8'd0, 1'b0, '0},
      '{-1, -1, OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, '0},
      '{-1, -1, OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, '0},
      '{-1, -1, OP_PIXEL, 8'd0, 8'd0, 8'd255, 1'b0, '0},
      '{-1, -1, OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, '0},
      '{-1, -1, OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, '0},
      '{-1, -1, OP_DRAIN, 8'd0, 8'd0, 8'd0, 1'b0, '0},
      '{-1, -1, OP_DRAIN, 8'd0, 8'd0, 8'd0, 1'b0, '0},
      '{-1, -1, OP_DRAIN, 8'd0, 8'd0, 8'd0, 1'b0, '0},
      '{-1, -1, OP_DRAIN, 8'd0, 8'd0, 8'd0, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b1}}
   };

   // result side
   initial begin
      int stall;
      rsp_type exp_r;
      forever begin
         stall = draw_gap();
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid || reset);
         if (blur_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction: %p", rsp_data);
         end else begin
            exp_r = blur_due.pop_front();
            if (rsp_data !== exp_r) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_r, rsp_data);
            end
         end
      end
   end

   initial begin
      req_type t;
      int plan_w [4] = '{0, 2047, 5, 3};
      int plan_h [4] = '{3, 1, 0, 4095};
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      cfg_w = 640;
      cfg_h = 480;
      col_in = 0;
      row_in = 0;
      col_out = 0;
      row_out = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].cw >= 0) configure(dir_rows[i].cw, dir_rows[i].ch);
         t.op = dir_rows[i].op;
         t.red_in = dir_rows[i].rr;
         t.green_in = dir_rows[i].gg;
         t.blue_in = dir_rows[i].bb;
         send(t, dir_rows[i].typed, dir_rows[i].want);
      end

      for (int p = 0; p < 4; p++) begin
         configure(plan_w[p], plan_h[p]);
         run_frame((plan_h[p] == 4095 || plan_w[p] > 12) ? 20 : -1);
      end
      while (items_sent < 550) begin
         quiet = ($urandom_range(0, 4) == 0);
         configure($urandom_range(1, 12), $urandom_range(1, 8));
         repeat ($urandom_range(1, 2))
            run_frame($urandom_range(0, 6) == 0 ? $urandom_range(0, 30) : -1);
      end

      @(negedge clock);
      req_valid = 1'b0;
      wait (blur_due.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #60000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
